FILE: sv/timed_release_min_heap_defines.svh
// ----------------------------------------------------------------------------
// timed_release_min_heap_defines
// Assertion macros shared by the timed release heap RTL.
// ----------------------------------------------------------------------------
`ifndef TIMED_RELEASE_MIN_HEAP_DEFINES_SVH
`define TIMED_RELEASE_MIN_HEAP_DEFINES_SVH

// Concurrent check that a property holds at every clock outside reset.
`define TRMH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that a condition never holds outside reset.
`define TRMH_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/trmh_pkg.sv
// ----------------------------------------------------------------------------
// trmh_pkg
// Shared types and constants of the timed release heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package trmh_pkg;
	localparam int IdW = 16;
	localparam int KeyW = 32;
	localparam int EntW = IdW + KeyW;
	localparam int DefCapacity = 64;
	localparam int MaxResults = 64;

	localparam logic OpSchedule = 1'b0;
	localparam logic OpRelease = 1'b1;

	typedef struct packed {
		logic [IdW-1:0]  id;
		logic [KeyW-1:0] key;
	} entry_t;
endpackage
`default_nettype wire

FILE: sv/trmh_ram.sv
// ----------------------------------------------------------------------------
// trmh_ram
// Generic single-write, dual-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module trmh_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr_a,
	output logic      [Width-1:0]         rdata_a,
	input  wire logic [$clog2(Depth)-1:0] raddr_b,
	output logic      [Width-1:0]         rdata_b
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

FILE: sv/timed_release_min_heap.sv
// ----------------------------------------------------------------------------
// timed_release_min_heap
// Release queue on a binary min-heap in RAM, keyed on release time.
//
// Channel  Direction  Beat
// in       sink       operation, entry_id, due_time, now_time
// out      source     released, out_id, out_time, last, rejected
//
// A schedule climbs one heap level per parent read (S_UPRD) and compare (S_UPCMP).
// Each root check reads (S_RTRD) and tests (S_RTCHK) the root. Each released
// entry fetches the last entry (S_MVRD), then sinks a level per S_DNRD and S_DNCMP.
// A released entry is held until the next root check decides its last flag.
// The heap RAM needs no clearing; reset only clears the counts, valid_out and state.
// A stalled output beat holds the sequencer in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "timed_release_min_heap_defines.svh"
module timed_release_min_heap import trmh_pkg::*; #(
	parameter int CAPACITY = DefCapacity
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	output logic                 ready_in,
	input  wire logic            operation,
	input  wire logic [IdW-1:0]  entry_id,
	input  wire logic [KeyW-1:0] due_time,
	input  wire logic [KeyW-1:0] now_time,
	output logic                 valid_out,
	input  wire logic            ready_out,
	output logic                 released,
	output logic [IdW-1:0]       out_id,
	output logic [KeyW-1:0]      out_time,
	output logic                 last,
	output logic                 rejected
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam int RW = $clog2(MaxResults + 1);

	localparam logic [3:0] S_IDLE = 4'd0, S_UPRD = 4'd1, S_UPCMP = 4'd2,
		S_RTRD = 4'd3, S_RTCHK = 4'd4, S_OUT = 4'd5, S_MVRD = 4'd6,
		S_DNRD = 4'd7, S_DNCMP = 4'd8, S_DONE = 4'd9;

	logic [3:0]      state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   cur_q;
	entry_t          mov_q;
	entry_t          pend_q;
	logic [KeyW-1:0] now_q;
	logic            rej_q;
	logic [RW-1:0]   nres_q;

	logic            we;
	logic [AW-1:0]   waddr, ra, rb;
	entry_t          wdata, rda, rdb;

	trmh_ram #(.Width(EntW), .Depth(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb)
	);

	logic [AW:0] lc, rc, par;
	assign par = ({1'b0, cur_q} - 1'b1) >> 1;
	assign lc = {cur_q, 1'b1};
	assign rc = lc + 1'b1;

	assign ready_in = (state_q == S_IDLE);

	always_comb begin
		ra = par[AW-1:0];
		rb = rc[AW-1:0];
		we = 1'b0;
		waddr = cur_q;
		wdata = mov_q;
		unique case (state_q)
			S_UPRD: ra = par[AW-1:0];
			S_RTRD: ra = '0;
			S_MVRD: ra = AW'(count_q);
			S_DNRD: begin
				ra = lc[AW-1:0];
				rb = rc[AW-1:0];
			end
			S_UPCMP: begin
				we = 1'b1;
				waddr = cur_q;
				wdata = ((cur_q != '0) && (mov_q.key < rda.key)) ? rda : mov_q;
			end
			S_DNCMP: begin
				we = 1'b1;
				waddr = cur_q;
				wdata = mov_q;
				if ({1'b0, lc} < {1'b0, count_q}) begin
					if ((rc == count_q) || (rda.key < rdb.key)) begin
						if (!(mov_q.key < rda.key)) wdata = rda;
					end else begin
						if (!(mov_q.key < rdb.key)) wdata = rdb;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			nres_q <= '0;
			valid_out <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (valid_in) begin
					now_q <= now_time;
					nres_q <= '0;
					mov_q <= '{id: entry_id, key: due_time};
					cur_q <= AW'(count_q);
					rej_q <= 1'b0;
					if (operation == OpSchedule) begin
						if (count_q == CW'(CAPACITY)) begin
							rej_q <= 1'b1;
							state_q <= S_RTRD;
						end else begin
							count_q <= count_q + 1'b1;
							state_q <= (count_q == '0) ? S_UPCMP : S_UPRD;
						end
					end else begin
						state_q <= S_RTRD;
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if ((cur_q != '0) && (mov_q.key < rda.key)) begin
						cur_q <= par[AW-1:0];
						state_q <= (par == '0) ? S_UPCMP : S_UPRD;
					end else begin
						state_q <= S_RTRD;
					end
				end
				S_RTRD: state_q <= S_RTCHK;
				S_RTCHK: begin
					rejected <= rej_q;
					if ((nres_q != RW'(MaxResults)) && (count_q != '0)
							&& (rda.key <= now_q)) begin
						pend_q <= rda;
						nres_q <= nres_q + 1'b1;
						count_q <= count_q - 1'b1;
						cur_q <= '0;
						if (nres_q != '0) begin
							valid_out <= 1'b1;
							released <= 1'b1;
							out_id <= pend_q.id;
							out_time <= pend_q.key;
							last <= 1'b0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_MVRD;
						end
					end else begin
						valid_out <= 1'b1;
						last <= 1'b1;
						if (nres_q != '0) begin
							released <= 1'b1;
							out_id <= pend_q.id;
							out_time <= pend_q.key;
						end else begin
							released <= 1'b0;
							out_id <= '0;
							out_time <= '0;
						end
						state_q <= S_DONE;
					end
				end
				S_OUT: if (ready_out) begin
					valid_out <= 1'b0;
					state_q <= S_MVRD;
				end
				S_MVRD: state_q <= S_DNRD;
				S_DNRD: begin
					if (cur_q == '0) mov_q <= rda;
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					state_q <= S_RTRD;
					if ({1'b0, lc} < {1'b0, count_q}) begin
						if ((rc == count_q) || (rda.key < rdb.key)) begin
							if (!(mov_q.key < rda.key)) begin
								cur_q <= lc[AW-1:0];
								state_q <= S_DNRD;
							end
						end else if (!(mov_q.key < rdb.key)) begin
							cur_q <= rc[AW-1:0];
							state_q <= S_DNRD;
						end
					end
				end
				S_DONE: if (ready_out) begin
					valid_out <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TRMH_ASSERT(a_cnt_le_cap, clk, arst_n, (count_q <= CW'(CAPACITY)), "count over capacity")
	`TRMH_ASSERT(a_ready_idle, clk, arst_n, (ready_in |-> !valid_out), "ready with beat pending")
	`TRMH_ASSERT(a_nres_cap, clk, arst_n, (nres_q <= RW'(MaxResults)), "too many results")
	`TRMH_NEVER(a_empty_last, clk, arst_n, (valid_out && !released && !last), "empty beat not last")
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Timed release heap testbench
// Drives schedule and release items into the heap and checks every beat of
// the released stream against a behavioral min-heap kept in step with the
// accepted input beats. Covers key extremes, equal keys, a full heap,
// release caps and random traffic under several idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench import trmh_pkg::*;;

	localparam int Cap = DefCapacity;
	localparam longint CycleLimit = 2000000;

	typedef struct packed {
		logic            rel;
		logic [IdW-1:0]  id;
		logic [KeyW-1:0] key;
		logic            lst;
		logic            rej;
	} release_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid_in = 1'b0;
	logic ready_in;
	logic operation = OpRelease;
	logic [IdW-1:0] entry_id = '0;
	logic [KeyW-1:0] due_time = '0;
	logic [KeyW-1:0] now_time = '0;
	logic valid_out;
	logic ready_out = 1'b0;
	logic released;
	logic [IdW-1:0] out_id;
	logic [KeyW-1:0] out_time;
	logic last;
	logic rejected;

	entry_t model_heap [Cap];
	int model_count = 0;
	release_beat_t pending_releases [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	longint cycles = 0;

	timed_release_min_heap dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic bit heap_push(entry_t e);
		int cur;
		entry_t t;
		if (model_count >= Cap) return 1'b0;
		cur = model_count;
		model_heap[cur] = e;
		while (cur > 0 && model_heap[cur].key < model_heap[(cur - 1) / 2].key) begin
			t = model_heap[cur];
			model_heap[cur] = model_heap[(cur - 1) / 2];
			model_heap[(cur - 1) / 2] = t;
			cur = (cur - 1) / 2;
		end
		model_count++;
		return 1'b1;
	endfunction

	function automatic void heap_pop_root();
		int cur;
		int l;
		int child;
		entry_t t;
		cur = 0;
		model_count--;
		model_heap[0] = model_heap[model_count];
		while (cur * 2 + 1 < model_count) begin
			l = cur * 2 + 1;
			if (l + 1 == model_count) child = l;
			else child = (model_heap[l].key < model_heap[l + 1].key) ? l : l + 1;
			if (model_heap[cur].key < model_heap[child].key) break;
			t = model_heap[cur];
			model_heap[cur] = model_heap[child];
			model_heap[child] = t;
			cur = child;
		end
	endfunction

	function automatic void predict_releases(logic op, logic [IdW-1:0] id,
			logic [KeyW-1:0] due, logic [KeyW-1:0] now);
		logic rej;
		int n;
		release_beat_t b;
		rej = 1'b0;
		n = 0;
		if (op == OpSchedule && !heap_push('{id: id, key: due})) rej = 1'b1;
		while (n < MaxResults && model_count > 0 && model_heap[0].key <= now) begin
			b = '{rel: 1'b1, id: model_heap[0].id, key: model_heap[0].key,
				lst: 1'b0, rej: rej};
			heap_pop_root();
			pending_releases.push_back(b);
			n++;
		end
		if (n == 0) pending_releases.push_back('{rel: 1'b0, id: '0, key: '0, lst: 1'b1, rej: rej});
		else pending_releases[$].lst = 1'b1;
	endfunction

	task automatic send_item(logic op, logic [IdW-1:0] id, logic [KeyW-1:0] due,
			logic [KeyW-1:0] now);
		do @(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
		valid_in <= 1'b1;
		operation <= op;
		entry_id <= id;
		due_time <= due;
		now_time <= now;
		@(posedge clk);
		while (!ready_in) @(posedge clk);
		predict_releases(op, id, due, now);
		@(negedge clk);
		valid_in <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_releases.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (recv_hold) ready_out <= 1'b0;
		else ready_out <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		release_beat_t e;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (arst_n && valid_out && ready_out) begin
			if (pending_releases.size() == 0) begin
				$error("unexpected beat id=%0h time=%0h", out_id, out_time);
				errors++;
			end else begin
				e = pending_releases.pop_front();
				if (released !== e.rel) begin
					$error("released: expected %0h got %0h", e.rel, released); errors++;
				end
				if (out_id !== e.id) begin
					$error("out_id: expected %0h got %0h", e.id, out_id); errors++;
				end
				if (out_time !== e.key) begin
					$error("out_time: expected %0h got %0h", e.key, out_time); errors++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0h got %0h", e.lst, last); errors++;
				end
				if (rejected !== e.rej) begin
					$error("rejected: expected %0h got %0h", e.rej, rejected); errors++;
				end
			end
		end
	end

	task automatic test_extremes();
		send_item(OpRelease, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OpSchedule, 16'h0000, 32'h0000_0000, 32'h0000_0000);
		send_item(OpSchedule, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_item(OpSchedule, 16'h1234, 32'h10, 32'h0);
		send_item(OpSchedule, 16'h1235, 32'h10, 32'h0);
		send_item(OpSchedule, 16'h1236, 32'h10, 32'h0);
		send_item(OpSchedule, 16'hA5A5, 32'h8, 32'h0);
		send_item(OpRelease, 16'h0, 32'h0, 32'h10);
		send_item(OpRelease, 16'h0, 32'h0, 32'hFFFF_FFFF);
		send_item(OpRelease, 16'h0, 32'h0, 32'hFFFF_FFFF);
	endtask

	task automatic test_full_heap();
		for (int i = 0; i < Cap + 3; i++)
			send_item(OpSchedule, 16'(i), 32'($urandom_range(7)) + 32'h100, 32'h0);
		send_item(OpRelease, 16'h0, 32'h0, 32'h200);
		wait_drained();
	endtask

	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1'b1;
				repeat (3000) @(negedge clk);
				recv_hold = 1'b0;
			end
			for (int i = 0; i < 20; i++)
				send_item(OpSchedule, 16'($urandom), 32'($urandom_range(50)),
					32'($urandom_range(50)));
		join
		wait_drained();
	endtask

	task automatic test_random(int count);
		logic [KeyW-1:0] base;
		logic [KeyW-1:0] due;
		for (int i = 0; i < count; i++) begin
			base = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(1000));
			due = ($urandom_range(4) == 0) ? 32'($urandom) : base + 32'($urandom_range(300));
			if ($urandom_range(3) == 0)
				send_item(OpRelease, 16'($urandom), 32'($urandom), base);
			else
				send_item(OpSchedule, 16'($urandom), due, base);
		end
		send_item(OpRelease, 16'h0, 32'h0, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_idle_pct = 20;
		recv_idle_pct = 50;
		test_extremes();
		wait_drained();
		test_full_heap();
		test_random(100);
		send_idle_pct = 50;
		recv_idle_pct = 20;
		test_backpressure();
		test_random(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(60);
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
